@@ rtl/core/wbpc_pkg.sv @@
package wbpc_pkg;

    // sample and arithmetic widths
    localparam int SAMPLE_W   = 16;
    localparam int NARROW_W   = 8;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W - GAIN_FRAC;   // gained channel value
    localparam int SAT_W      = 16;
    localparam int SAT_FRAC   = 12;
    localparam int CURVE_W    = 32;
    localparam int CURVE_FRAC = 28;                              // Q.12 blend times Q16.16 gain

    // tone-curve table
    localparam int CURVE_DEPTH = 65536;
    localparam int CURVE_AW    = $clog2(CURVE_DEPTH);
    localparam int ADDR_W      = 16;

    // sample range: max is 256 in narrow mode, 65536 in wide mode
    localparam int MAX_W = SAMPLE_W + 1;
    localparam logic [MAX_W-1:0]    MAX_NARROW = MAX_W'(256);
    localparam logic [MAX_W-1:0]    MAX_WIDE   = MAX_W'(65536);
    localparam logic [SAMPLE_W-1:0] TOP_NARROW = SAMPLE_W'(256 - 1);
    localparam logic [SAMPLE_W-1:0] TOP_WIDE   = SAMPLE_W'(65536 - 1);

    // blend datapath
    localparam int POS_W   = CURVE_AW + SAT_FRAC;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int BLEND_W = SAT_W + 1 + DIFF_W;
    localparam int T_W     = BLEND_W;
    localparam int T_HALF  = T_W / 2;
    localparam int PP_W    = (T_W - T_HALF) + CURVE_W;
    localparam int SUM_W   = T_W + CURVE_W;
    localparam int Q_W     = SUM_W - CURVE_FRAC;

    localparam int LANES = 3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_FACTOR   = 3'd5;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [SAT_W-1:0]  SAT_ONE  = SAT_W'(4096);

    typedef struct packed {
        logic wide;
        logic clip;
    } wbpc_mode_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } wbpc_en_t;

    function automatic logic [SAMPLE_W-1:0] sample_top(input logic wide);
        return wide ? TOP_WIDE : TOP_NARROW;
    endfunction

    function automatic logic [MAX_W-1:0] sample_max(input logic wide);
        return wide ? MAX_WIDE : MAX_NARROW;
    endfunction

endpackage

@@ rtl/core/wbpc_gain_lane.sv @@
module wbpc_gain_lane import wbpc_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic                wide,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]   gain,
    output logic [PROD_W-1:0]   prod
);

    logic [SAMPLE_W-1:0]        sample_used;
    logic [SAMPLE_W+GAIN_W-1:0] full;
    logic [PROD_W-1:0]          prod_reg;

    always_comb begin
        sample_used = wide ? sample : SAMPLE_W'(sample[NARROW_W-1:0]);
        full = (SAMPLE_W+GAIN_W)'(sample_used) * (SAMPLE_W+GAIN_W)'(gain);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= full[SAMPLE_W+GAIN_W-1:GAIN_FRAC];
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/wbpc_merge.sv @@
module wbpc_merge import wbpc_pkg::*; (
    input  wbpc_mode_t          mode,
    input  logic [PROD_W-1:0]   prod [LANES],
    output logic [CURVE_AW-1:0] idx
);

    logic [PROD_W-1:0] peak;
    logic [PROD_W-1:0] top;

    always_comb begin
        peak = prod[0];
        for (int i = 1; i < LANES; i++) begin
            if (prod[i] > peak) begin
                peak = prod[i];
            end
        end
        top = PROD_W'(sample_top(mode.wide));
        if (mode.clip && peak > top) begin
            peak = top;
        end
        // selector saturates at the last table entry
        if (peak > PROD_W'(CURVE_DEPTH - 1)) begin
            idx = CURVE_AW'(CURVE_DEPTH - 1);
        end else begin
            idx = peak[CURVE_AW-1:0];
        end
    end

endmodule

@@ rtl/core/wbpc_tone_lane.sv @@
module wbpc_tone_lane import wbpc_pkg::*; (
    input  logic                aclk,
    input  wbpc_en_t            en,
    input  wbpc_mode_t          mode,
    input  logic [SAT_W-1:0]    sat,
    input  logic [PROD_W-1:0]   prod,
    input  logic [CURVE_AW-1:0] idx,
    input  logic [CURVE_W-1:0]  curve,
    output logic [SAMPLE_W-1:0] sample_out
);

    logic [PROD_W-1:0]         prod2_reg;

    logic [PROD_W-1:0]         r;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [BLEND_W-1:0] blend;
    logic signed [BLEND_W-1:0] blend3_reg;
    logic [POS_W-1:0]          pos3_reg;
    logic [CURVE_W-1:0]        curve3_reg;

    logic signed [BLEND_W:0]   t_sum;
    logic [T_W-1:0]            t4_reg;
    logic [CURVE_W-1:0]        curve4_reg;

    logic [PP_W-1:0]           lo5_reg;
    logic [PP_W-1:0]           hi5_reg;

    logic [SUM_W-1:0]          sum;
    logic [Q_W-1:0]            q;
    logic [SAMPLE_W-1:0]       top;
    logic [SAMPLE_W-1:0]       out6_reg;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            prod2_reg <= prod;
        end
    end

    // blend toward the selector: idx*4096 + sat*(r - idx)
    always_comb begin
        if (mode.clip && prod2_reg > PROD_W'(sample_max(mode.wide))) begin
            r = PROD_W'(sample_max(mode.wide));
        end else begin
            r = prod2_reg;
        end
        diff  = $signed({1'b0, r}) - $signed({{(DIFF_W-CURVE_AW){1'b0}}, idx});
        blend = $signed({1'b0, sat}) * diff;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            blend3_reg <= blend;
            pos3_reg   <= {idx, {SAT_FRAC{1'b0}}};
            curve3_reg <= curve;
        end
    end

    assign t_sum = $signed({{(BLEND_W+1-POS_W){1'b0}}, pos3_reg})
                 + $signed({blend3_reg[BLEND_W-1], blend3_reg});

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            t4_reg     <= t_sum[BLEND_W] ? '0 : t_sum[T_W-1:0];
            curve4_reg <= curve3_reg;
        end
    end

    // 42 x 32 product split into two partial products
    always_ff @(posedge aclk) begin
        if (en.s5) begin
            lo5_reg <= PP_W'(t4_reg[T_HALF-1:0]) * PP_W'(curve4_reg);
            hi5_reg <= PP_W'(t4_reg[T_W-1:T_HALF]) * PP_W'(curve4_reg);
        end
    end

    always_comb begin
        sum = {hi5_reg, {T_HALF{1'b0}}} + SUM_W'(lo5_reg);
        q   = sum[SUM_W-1:CURVE_FRAC];
        top = sample_top(mode.wide);
    end

    always_ff @(posedge aclk) begin
        if (en.s6) begin
            out6_reg <= (q > Q_W'(top)) ? top : q[SAMPLE_W-1:0];
        end
    end

    assign sample_out = out6_reg;

endmodule

@@ rtl/core/white_balance_pixel_correct.sv @@
// White balance with tone-curve gain. Takes one beat per clock, pixel or table write,
// while the output is not stalled, and returns one corrected pixel per pixel beat from
// the last stage; table writes give no result. Throughput is set by the six-stage
// pipeline and the single tone-curve memory (65536 x 32, one write and one registered
// read per cycle, both in the same stage so writes and reads stay in stream order).
// Each channel is gained (Q8.16), the largest gained value picks the curve entry, then
// each channel is blended by saturation_factor (Q4.12), scaled by the curve gain
// (Q16.16) and clamped to the sample range. The curve has no reset: entries must be
// written before any pixel selects them. Configuration is to be written only while the
// block is idle, which the block itself does not enforce; cfg_ready is always high.
module white_balance_pixel_correct import wbpc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,  // blue_in, green_in, red_in, table_address,
                                            // table_value
    input  logic                  s_tuser,  // kind
    input  logic                  s_tlast,  // last_pixel

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,  // blue_out, green_out, red_out
    output logic                  m_tlast,  // last_pixel_out

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTAGE = 6;

    // configuration
    logic              wide_reg;
    logic              clip_reg;
    logic [GAIN_W-1:0] gain_reg [LANES];   // blue, green, red
    logic [SAT_W-1:0]  sat_reg;
    wbpc_mode_t        mode;

    assign cfg_ready = 1'b1;
    assign mode.wide = wide_reg;
    assign mode.clip = clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg    <= 1'b0;
            clip_reg    <= 1'b1;
            gain_reg[0] <= GAIN_ONE;
            gain_reg[1] <= GAIN_ONE;
            gain_reg[2] <= GAIN_ONE;
            sat_reg     <= SAT_ONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WIDE_SAMPLES: wide_reg    <= cfg_data[0];
                CFG_CLIP_SAT:     clip_reg    <= cfg_data[0];
                CFG_RED_GAIN:     gain_reg[2] <= cfg_data[GAIN_W-1:0];
                CFG_GREEN_GAIN:   gain_reg[1] <= cfg_data[GAIN_W-1:0];
                CFG_BLUE_GAIN:    gain_reg[0] <= cfg_data[GAIN_W-1:0];
                CFG_SAT_FACTOR:   sat_reg     <= cfg_data[SAT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline valids and per-stage advance
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;
    wbpc_en_t          lane_en;

    always_comb begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready   = en[0];
    assign lane_en.s2 = en[1];
    assign lane_en.s3 = en[2];
    assign lane_en.s4 = en[3];
    assign lane_en.s5 = en[4];
    assign lane_en.s6 = en[5];

    // stage 1 side data
    logic                kind1_reg;
    logic [NSTAGE-1:0]   last_reg;
    logic [ADDR_W-1:0]   addr1_reg;
    logic [CURVE_W-1:0]  value1_reg;
    // stage 2
    logic                kind2_reg;
    logic [CURVE_AW-1:0] idx2_reg;
    logic [CURVE_W-1:0]  curve2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= s_tvalid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            // table writes leave the pipeline once the memory has taken them
            if (en[2]) valid_reg[2] <= valid_reg[1] && !kind2_reg;
            for (int k = 3; k < NSTAGE; k++) begin
                if (en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            kind1_reg   <= s_tuser;
            last_reg[0] <= s_tlast;
            addr1_reg   <= s_tdata[63:48];
            value1_reg  <= s_tdata[95:64];
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (en[k]) last_reg[k] <= last_reg[k-1];
        end
    end

    // gain lanes
    logic [SAMPLE_W-1:0] sample_in [LANES];
    logic [PROD_W-1:0]   prod      [LANES];
    logic [SAMPLE_W-1:0] sample_out[LANES];
    logic [CURVE_AW-1:0] idx;

    for (genvar i = 0; i < LANES; i++) begin : g_gain
        assign sample_in[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
        wbpc_gain_lane u_gain (
            .aclk   (aclk),
            .en     (en[0]),
            .wide   (wide_reg),
            .sample (sample_in[i]),
            .gain   (gain_reg[i]),
            .prod   (prod[i])
        );
    end

    wbpc_merge u_merge (
        .mode (mode),
        .prod (prod),
        .idx  (idx)
    );

    // tone-curve memory: write and read in the same stage keeps stream order
    logic [CURVE_W-1:0] curve_mem [CURVE_DEPTH];
    logic               curve_we;

    assign curve_we = valid_reg[0] && kind1_reg && en[1]
                   && ({1'b0, addr1_reg} < (ADDR_W+1)'(CURVE_DEPTH));

    always_ff @(posedge aclk) begin
        if (curve_we) begin
            curve_mem[addr1_reg[CURVE_AW-1:0]] <= value1_reg;
        end
        if (en[1]) begin
            curve2_reg <= curve_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            kind2_reg <= kind1_reg;
            idx2_reg  <= idx;
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_tone
        wbpc_tone_lane u_tone (
            .aclk       (aclk),
            .en         (lane_en),
            .mode       (mode),
            .sat        (sat_reg),
            .prod       (prod[i]),
            .idx        (idx2_reg),
            .curve      (curve2_reg),
            .sample_out (sample_out[i])
        );
    end

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tlast  = last_reg[NSTAGE-1];
    assign m_tdata  = {sample_out[2], sample_out[1], sample_out[0]};

endmodule

@@ test/white_balance_pixel_correct_tb.sv @@
`timescale 1ns / 1ps

module white_balance_pixel_correct_tb;
    import wbpc_pkg::*;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam logic EXP_CALC   = 1'b0;
    localparam logic EXP_TYPED  = 1'b1;

    localparam int PIPE_SLACK    = 10;
    localparam int STALL_LIMIT   = 5000;
    localparam int SEG_PIXELS    = 140;
    localparam int HOLD_OFF_LEN  = 300;

    typedef struct packed {
        logic        kind;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic        last;
        logic [15:0] addr;
        logic [31:0] value;
    } wb_beat_t;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
        logic        last;
    } wb_pixel_t;

    typedef struct packed {
        wb_beat_t  beat;
        logic      typed;
        wb_pixel_t want;
    } dir_row_t;

    localparam wb_pixel_t NO_WANT = '0;

    // reset config: 8-bit samples, clip on, unity gains and saturation
    localparam dir_row_t DIRECTED [21] = '{
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 32'h0001_0000},
          EXP_CALC, NO_WANT},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h00FF, 32'h0001_0000},
          EXP_CALC, NO_WANT},
        '{'{KIND_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF},
          EXP_CALC, NO_WANT},
        '{'{KIND_PIXEL, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 32'hFFFF_FFFF},
          EXP_TYPED, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
        '{'{KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h00FF, 16'h00FF, 16'h00FF, 1'b1}},
        '{'{KIND_PIXEL, 16'h00FF, 16'h00FF, 16'h00FF, 1'b0, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h00FF, 16'h00FF, 16'h00FF, 1'b0}},
        // upper sample bits ignored in 8-bit mode
        '{'{KIND_PIXEL, 16'h0100, 16'h0200, 16'h01FF, 1'b0, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h0000, 16'h0000, 16'h00FF, 1'b0}},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0080, 32'h0000_8000},
          EXP_CALC, NO_WANT},
        '{'{KIND_PIXEL, 16'h0080, 16'h0040, 16'h0020, 1'b0, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h0040, 16'h0020, 16'h0010, 1'b0}},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h00FF, 32'h0000_0000},
          EXP_CALC, NO_WANT},
        // zero curve gain
        '{'{KIND_PIXEL, 16'h000A, 16'h0014, 16'h00FF, 1'b0, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h00FF, 32'hFFFF_FFFF},
          EXP_CALC, NO_WANT},
        // huge product saturates
        '{'{KIND_PIXEL, 16'h00FF, 16'h0001, 16'h0000, 1'b0, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h00FF, 16'h00FF, 16'h0000, 1'b0}},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0001, 32'h0001_0000},
          EXP_CALC, NO_WANT},
        '{'{KIND_PIXEL, 16'h0001, 16'h0000, 16'h0000, 1'b1, 16'h0000, 32'h0000_0000},
          EXP_TYPED, '{16'h0001, 16'h0000, 16'h0000, 1'b1}},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0011, 32'h0001_8000},
          EXP_CALC, NO_WANT},
        '{'{KIND_PIXEL, 16'h0011, 16'h0007, 16'h000C, 1'b0, 16'h0000, 32'h0000_0000},
          EXP_CALC, NO_WANT},
        '{'{KIND_PIXEL, 16'h1234, 16'hABCD, 16'h5A5A, 1'b1, 16'h5555, 32'h1234_5678},
          EXP_CALC, NO_WANT},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h8000, 32'h5555_AAAA},
          EXP_CALC, NO_WANT},
        '{'{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h7FFF, 32'hAAAA_5555},
          EXP_CALC, NO_WANT},
        '{'{KIND_PIXEL, 16'h00FF, 16'h00FE, 16'h0080, 1'b0, 16'hAAAA, 32'h0000_0000},
          EXP_CALC, NO_WANT}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [95:0]           s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    bit [31:0] curve_gain [CURVE_DEPTH];
    bit        curve_valid [CURVE_DEPTH];
    bit        wide_q;
    bit        clip_q;
    bit [23:0] gain_red;
    bit [23:0] gain_green;
    bit [23:0] gain_blue;
    bit [15:0] sat_factor;

    wb_pixel_t pixel_expect_q [$];
    int        mismatch_count;
    int        result_count;
    int        src_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_left;
    int        quiet_cycles;

    white_balance_pixel_correct u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit [23:0] gain_channel(bit [15:0] s, bit [23:0] g);
        bit [15:0] sm;
        bit [39:0] prod;
        sm   = wide_q ? s : {8'h00, s[7:0]};
        prod = sm * g;
        return prod[39:16];
    endfunction

    function automatic bit [15:0] curve_index(wb_beat_t b);
        bit [23:0] pb;
        bit [23:0] pg;
        bit [23:0] pr;
        bit [23:0] v;
        bit [23:0] top;
        pb  = gain_channel(b.blue, gain_blue);
        pg  = gain_channel(b.green, gain_green);
        pr  = gain_channel(b.red, gain_red);
        top = wide_q ? 24'd65535 : 24'd255;
        v   = (pb > pg) ? pb : pg;
        if (pr > v) v = pr;
        if (clip_q && v > top) v = top;
        if (v > CURVE_DEPTH - 1) v = CURVE_DEPTH - 1;
        return v[15:0];
    endfunction

    // blend toward the selector, scale by curve gain, clamp to 0..max-1
    function automatic bit [15:0] blend_scale(bit [23:0] p, bit [15:0] idx, bit [31:0] c);
        longint     maxv;
        longint     r;
        longint     t;
        longint     idx_l;
        bit [63:0]  t_u;
        bit [127:0] prod;
        bit [127:0] q;
        maxv  = wide_q ? 65536 : 256;
        idx_l = idx;
        r     = p;
        if (clip_q && r > maxv) r = maxv;
        t = idx_l * (1 << SAT_FRAC) + longint'(sat_factor) * (r - idx_l);
        if (t <= 0 || c == 0) return 16'h0000;
        t_u  = t;
        prod = 128'(t_u) * 128'(c);
        q    = prod >> CURVE_FRAC;
        if (q > 128'(maxv - 1)) return 16'(maxv - 1);
        return q[15:0];
    endfunction

    function automatic wb_pixel_t correct_pixel(wb_beat_t b);
        bit [15:0] idx;
        bit [31:0] c;
        wb_pixel_t o;
        idx     = curve_index(b);
        c       = curve_gain[idx];
        o.blue  = blend_scale(gain_channel(b.blue, gain_blue), idx, c);
        o.green = blend_scale(gain_channel(b.green, gain_green), idx, c);
        o.red   = blend_scale(gain_channel(b.red, gain_red), idx, c);
        o.last  = b.last;
        return o;
    endfunction

    function automatic bit [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 511));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [23:0] rand_gain();
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(32'h4000, 32'h28000));
        endcase
    endfunction

    function automatic bit [15:0] rand_sat();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(32'h800, 32'h2000));
        endcase
    endfunction

    function automatic bit [31:0] rand_curve_value();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h3FFFF);
        endcase
    endfunction

    function automatic wb_beat_t random_beat(logic kind);
        wb_beat_t b;
        b.kind  = kind;
        b.blue  = rand_sample();
        b.green = rand_sample();
        b.red   = rand_sample();
        b.last  = ($urandom_range(7) == 0);
        b.addr  = 16'($urandom);
        b.value = (kind == KIND_WRITE) ? rand_curve_value() : $urandom;
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatch_count++;
        $display("t=%0t result %0d %s: got 0x%h, expected 0x%h",
                 $time, result_count, what, got, want);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WIDE_SAMPLES: wide_q     = data[0];
            CFG_CLIP_SAT:     clip_q     = data[0];
            CFG_RED_GAIN:     gain_red   = data;
            CFG_GREEN_GAIN:   gain_green = data;
            CFG_BLUE_GAIN:    gain_blue  = data;
            CFG_SAT_FACTOR:   sat_factor = data[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(bit wide, bit clip, bit [23:0] gr, bit [23:0] gg,
                             bit [23:0] gb, bit [15:0] sat);
        write_register(CFG_WIDE_SAMPLES, CFG_DATA_W'(wide));
        write_register(CFG_CLIP_SAT, CFG_DATA_W'(clip));
        write_register(CFG_RED_GAIN, gr);
        write_register(CFG_GREEN_GAIN, gg);
        write_register(CFG_BLUE_GAIN, gb);
        write_register(CFG_SAT_FACTOR, CFG_DATA_W'(sat));
    endtask

    task automatic send_beat(wb_beat_t b, logic typed, wb_pixel_t want);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.kind;
        s_tlast  <= b.last;
        s_tdata  <= {b.value, b.addr, b.red, b.green, b.blue};
        do @(posedge aclk); while (!s_tready);
        if (b.kind == KIND_WRITE) begin
            curve_gain[b.addr]  = b.value;
            curve_valid[b.addr] = 1'b1;
        end else begin
            pixel_expect_q.push_back(typed ? want : correct_pixel(b));
        end
    endtask

    // an unwritten curve entry must never be read: write it just ahead of the pixel
    task automatic send_pixel(wb_beat_t b, logic typed, wb_pixel_t want, bit refresh);
        wb_beat_t  w;
        bit [15:0] idx;
        idx = curve_index(b);
        if (!curve_valid[idx] || refresh) begin
            w      = random_beat(KIND_WRITE);
            w.addr = idx;
            send_beat(w, EXP_CALC, NO_WANT);
        end
        send_beat(b, typed, want);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        wb_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pixel_expect_q.size() == 0) begin
                report_mismatch("result with none expected", m_tdata[15:0], 16'h0000);
            end else begin
                want = pixel_expect_q.pop_front();
                if (m_tdata[15:0] !== want.blue)
                    report_mismatch("blue_out", m_tdata[15:0], want.blue);
                if (m_tdata[31:16] !== want.green)
                    report_mismatch("green_out", m_tdata[31:16], want.green);
                if (m_tdata[47:32] !== want.red)
                    report_mismatch("red_out", m_tdata[47:32], want.red);
                if (m_tlast !== want.last)
                    report_mismatch("last_pixel_out", {15'h0, m_tlast}, {15'h0, want.last});
            end
        end
    end

    // nothing accepted on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_PIXEL;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_WIDE_SAMPLES;
        cfg_data       = '0;
        mismatch_count = 0;
        result_count   = 0;
        rx_hold_left   = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 16;
        rx_idle_pct    = 65;
        wide_q         = 1'b0;
        clip_q         = 1'b1;
        gain_red       = GAIN_ONE;
        gain_green     = GAIN_ONE;
        gain_blue      = GAIN_ONE;
        sat_factor     = SAT_ONE;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].beat.kind == KIND_WRITE)
                send_beat(DIRECTED[i].beat, EXP_CALC, NO_WANT);
            else
                send_pixel(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want, 1'b0);
        end
        drain_results();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin src_idle_pct = 16; rx_idle_pct = 65; end
                1: begin src_idle_pct = 65; rx_idle_pct = 16; end
                default: begin src_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (seg)
                0: configure(1'b0, 1'b1, rand_gain(), rand_gain(), rand_gain(), rand_sat());
                // selector runs past the table top, products saturate
                1: configure(1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
                2: configure(1'b1, 1'b1, 24'h000000, rand_gain(), 24'hFFFFFF, 16'h0000);
                3: configure(1'b0, 1'b0, rand_gain(), rand_gain(), rand_gain(), rand_sat());
                4: configure(1'b1, 1'b1, rand_gain(), rand_gain(), rand_gain(), rand_sat());
                default: configure(1'($urandom_range(1)), 1'($urandom_range(1)),
                                   rand_gain(), rand_gain(), rand_gain(), rand_sat());
            endcase
            for (int n = 0; n < SEG_PIXELS; n++) begin
                if (seg == 4 && n == 40)
                    rx_hold_left = HOLD_OFF_LEN;
                if (n == SEG_PIXELS / 2)
                    drain_results();
                if ($urandom_range(99) < 12)
                    send_beat(random_beat(KIND_WRITE), EXP_CALC, NO_WANT);
                else
                    send_pixel(random_beat(KIND_PIXEL), EXP_CALC, NO_WANT,
                               $urandom_range(9) == 0);
            end
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
